/* design/modular_exponentiation_defines.svh */
// Assertion macros shared by the modular exponentiation checker.
// No dependencies; included by name in each file that asserts.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define MODEXP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define MODEXP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/modexp_pkg.sv */
// Shared types and constants of the modular exponentiation block.
// No dependencies; imported by every module and interface of the block.
package modexp_pkg;

   // Fixed field and register widths.
   localparam int DATA_W            = 32;
   localparam int CSR_ADDR_W        = 3;
   localparam int OPERAND_WIDTH_DEF = 32;

   // Register indexes, taken from the word address.
   localparam logic REG_MODULUS  = 1'b0;
   localparam logic REG_EXPONENT = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_WAIT_REDUCE,
      ST_CHECK,
      ST_WAIT_ACC,
      ST_WAIT_SQ,
      ST_DONE
   } state_type;

   // Datapath operations.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_REDUCE,
      OP_ACC,
      OP_SQUARE,
      OP_SHIFT
   } op_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      op_type op;
      logic   out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mul_done;
      logic e_lsb;
      logic last_bit;
      logic m_zero;
   } status_type;

endpackage

/* design/modexp_if.sv */
// Valid/ready channel interfaces for the base word in and the result word out.
// Depends on modexp_pkg for the field width.
interface modexp_req_if;
   import modexp_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] base_value;

   modport source (output valid, output base_value, input ready);
   modport sink   (input valid, input base_value, output ready);
endinterface

interface modexp_rsp_if;
   import modexp_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] power_result;

   modport source (output valid, output power_result, input ready);
   modport sink   (input valid, input power_result, output ready);
endinterface

/* design/modular_exponentiation.sv */
// One word is worked on at a time; the bit-serial modular multiplier
// handles one multiplier bit per cycle.
// A new word is taken while a finished result still waits in the output register.
// Reset (synchronous, active high) idles the controller, empties the output register and
// sets modulus and exponent to 1.
module modular_exponentiation #(
   parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   modexp_req_if.sink                        req_chan,
   modexp_rsp_if.source                      rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [modexp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [modexp_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [modexp_pkg::DATA_W-1:0]     csr_prdata,
   output logic                              csr_pready
);
   import modexp_pkg::*;

   logic [DATA_W-1:0] modulus_ff, modulus_in;
   logic [DATA_W-1:0] exponent_ff, exponent_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              csr_write;
   logic              reg_index;
   logic              out_free;
   cmd_type           cmd;
   status_type        status;
   logic [DATA_W-1:0] power_result;

   // Decode register writes on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[2];

   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_MODULUS:  modulus_in  = csr_pwdata;
            REG_EXPONENT: exponent_in = csr_pwdata;
            default:      modulus_in  = modulus_ff;
         endcase
      end
   end

   // Return the addressed register on reads.
   always_comb begin
      unique case (reg_index)
         REG_MODULUS:  csr_prdata = modulus_ff;
         REG_EXPONENT: csr_prdata = exponent_ff;
         default:      csr_prdata = '0;
      endcase
   end

   // Hold the result word until the sink takes it.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = power_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= DATA_W'(1);
         exponent_ff  <= DATA_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.power_result = rsp_data_ff;

   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   modexp_dp #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .base_value   (req_chan.base_value),
      .modulus      (modulus_ff),
      .exponent     (exponent_ff),
      .status       (status),
      .power_result (power_result)
   );

endmodule

/* design/modexp_mulmod.sv */
// Bit-serial modular multiplier: result = x * y mod m, one bit of x per cycle.
// Depends on modexp_pkg; y must be below m, x may be any value.
module modexp_mulmod #(
   parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OPERAND_WIDTH-1:0] x,
   input  logic [OPERAND_WIDTH-1:0] y,
   input  logic [OPERAND_WIDTH-1:0] m,
   output logic                     done,
   output logic [OPERAND_WIDTH-1:0] result
);
   import modexp_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     r_ff, r_in;
   logic [W-1:0]     x_ff, x_in;
   logic [W-1:0]     y_ff, y_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [W:0] dbl;
   logic [W:0] dbl_red;
   logic [W:0] sum;
   logic [W:0] sum_red;

   // Double, reduce, conditionally add y, reduce again.
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
      sum     = x_ff[W-1] ? dbl_red + {1'b0, y_ff} : dbl_red;
      sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
   end

   // Sequence the steps, most significant bit of x first.
   always_comb begin
      r_in    = r_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         r_in    = '0;
         x_in    = x;
         y_in    = y;
         cnt_in  = CNT_W'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = sum_red[W-1:0];
         x_in   = {x_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state under reset; operands need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      r_ff <= r_in;
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

/* design/modexp_dp.sv */
// Datapath: operand registers, exponent shifter and the shared modular multiplier.
// Depends on modexp_pkg and modexp_mulmod; driven by commands from modexp_ctrl.
module modexp_dp #(
   parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  modexp_pkg::cmd_type           cmd,
   input  logic [modexp_pkg::DATA_W-1:0] base_value,
   input  logic [modexp_pkg::DATA_W-1:0] modulus,
   input  logic [modexp_pkg::DATA_W-1:0] exponent,
   output modexp_pkg::status_type        status,
   output logic [modexp_pkg::DATA_W-1:0] power_result
);
   import modexp_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     m_ff, m_in;
   logic [W-1:0]     e_ff, e_in;
   logic [W-1:0]     base_ff, base_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic [W-1:0]     sq_ff, sq_in;
   logic [CNT_W-1:0] bits_ff, bits_in;
   op_type           dest_ff, dest_in;

   logic         mul_start;
   logic [W-1:0] mul_x;
   logic [W-1:0] mul_y;
   logic         mul_done;
   logic [W-1:0] mul_result;

   // Pick multiplier operands for the issued operation.
   always_comb begin
      mul_start = 1'b0;
      mul_x     = sq_ff;
      mul_y     = sq_ff;
      case (cmd.op)
         OP_REDUCE: begin
            mul_start = 1'b1;
            mul_x     = base_ff;
            mul_y     = acc_ff;
         end
         OP_ACC: begin
            mul_start = 1'b1;
            mul_x     = acc_ff;
            mul_y     = sq_ff;
         end
         OP_SQUARE: begin
            mul_start = 1'b1;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   modexp_mulmod #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .x      (mul_x),
      .y      (mul_y),
      .m      (m_ff),
      .done   (mul_done),
      .result (mul_result)
   );

   // Load operands, write products back, advance the exponent.
   always_comb begin
      m_in    = m_ff;
      e_in    = e_ff;
      base_in = base_ff;
      acc_in  = acc_ff;
      sq_in   = sq_ff;
      bits_in = bits_ff;
      dest_in = dest_ff;
      if (mul_done) begin
         case (dest_ff)
            OP_ACC:  acc_in = mul_result;
            default: sq_in  = mul_result;
         endcase
      end
      if (mul_start) begin
         dest_in = cmd.op;
      end
      case (cmd.op)
         OP_LOAD: begin
            m_in    = modulus[W-1:0];
            e_in    = exponent[W-1:0];
            base_in = base_value[W-1:0];
            // Running product starts at 1 mod m.
            acc_in  = (modulus[W-1:0] == W'(1)) ? '0 : W'(1);
            bits_in = CNT_W'(W);
         end
         OP_SHIFT: begin
            e_in    = e_ff >> 1;
            bits_in = bits_ff - CNT_W'(1);
         end
         default: begin
            bits_in = bits_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff <= OP_NONE;
      end else begin
         dest_ff <= dest_in;
      end
      m_ff    <= m_in;
      e_ff    <= e_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      sq_ff   <= sq_in;
      bits_ff <= bits_in;
   end

   assign status.mul_done = mul_done;
   assign status.e_lsb    = e_ff[0];
   assign status.last_bit = (bits_ff == CNT_W'(1));
   assign status.m_zero   = (m_ff == '0);

   // A zero modulus answers with zero.
   assign power_result = status.m_zero ? '0 : DATA_W'(acc_ff);

endmodule

/* design/modexp_ctrl.sv */
// Controller: sequences base reduction and square-and-multiply over the exponent.
// Depends on modexp_pkg; issues commands to modexp_dp and reads its status.
module modexp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   out_free,
   input  modexp_pkg::status_type status,
   output modexp_pkg::cmd_type    cmd
);
   import modexp_pkg::*;

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:        if (req_valid) state_in = ST_REDUCE;
         ST_REDUCE:      state_in = status.m_zero ? ST_DONE : ST_WAIT_REDUCE;
         ST_WAIT_REDUCE: if (status.mul_done) state_in = ST_CHECK;
         ST_CHECK:       state_in = status.e_lsb ? ST_WAIT_ACC : ST_WAIT_SQ;
         ST_WAIT_ACC:    if (status.mul_done) state_in = ST_WAIT_SQ;
         ST_WAIT_SQ: begin
            if (status.mul_done) begin
               state_in = status.last_bit ? ST_DONE : ST_CHECK;
            end
         end
         ST_DONE:        if (out_free) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_REDUCE: begin
            if (!status.m_zero) cmd.op = OP_REDUCE;
         end
         ST_WAIT_REDUCE: begin
            cmd.op = OP_NONE;
         end
         ST_CHECK: begin
            cmd.op = status.e_lsb ? OP_ACC : OP_SQUARE;
         end
         ST_WAIT_ACC: begin
            if (status.mul_done) cmd.op = OP_SQUARE;
         end
         ST_WAIT_SQ: begin
            if (status.mul_done) cmd.op = OP_SHIFT;
         end
         ST_DONE: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/modexp_checker.sv */
// Port-level checker of the modular exponentiation block, bound to the top level.
// Depends on modexp_pkg and modular_exponentiation_defines.svh.
`include "modular_exponentiation_defines.svh"

module modexp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [modexp_pkg::DATA_W-1:0] rsp_data
);
   import modexp_pkg::*;

   // A pending result word stays and holds its value.
   `MODEXP_ASSERT(rsp_hold_a, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result word dropped or changed while stalled")

   // Reset empties the output register.
   `MODEXP_ASSERT_ALWAYS(rsp_reset_a, reset |=> !rsp_valid, "result word valid after reset")

   // One word at a time: an accepted base closes the input.
   `MODEXP_ASSERT(req_busy_a, req_valid && req_ready |=> !req_ready, "input still open after a word was accepted")

   // A new result comes only out of a finished computation.
   `MODEXP_ASSERT(rsp_source_a, $rose(rsp_valid) |-> $past(!req_ready), "result word appeared while the block was idle")

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.power_result)
);

/* verif/tb_modular_exponentiation.sv */
`timescale 1ns / 1ps
// Testbench for modular_exponentiation: programs modulus and exponent over the APB port,
// streams base words and checks every result word against a square-and-multiply predictor.
// Depends on modexp_pkg, modexp_if and the modular_exponentiation RTL.
module tb_modular_exponentiation;
   import modexp_pkg::*;

   localparam int BLOCK_LATENCY = 2200;
   localparam int LONG_HOLD     = 8000;

   // Expected result word together with the operands that produced it.
   typedef struct {
      logic [DATA_W-1:0] base_value;
      logic [DATA_W-1:0] modulus;
      logic [DATA_W-1:0] exponent;
      logic [DATA_W-1:0] power_result;
   } power_entry_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0]     csr_pwdata;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   modexp_req_if req_bus ();
   modexp_rsp_if rsp_bus ();

   power_entry_type   pending_powers[$];
   logic [DATA_W-1:0] cur_modulus;
   logic [DATA_W-1:0] cur_exponent;
   int                error_count;
   bit                quiet_run;
   int                hold_request;

   modular_exponentiation u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #40_000_000;
      $display("modular_exponentiation regression: fail");
      $finish;
   end

   // Print one mismatch line and count it.
   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Right-to-left square-and-multiply over all exponent bits.
   function automatic logic [DATA_W-1:0] predict_power(input logic [DATA_W-1:0] base,
                                                       input logic [DATA_W-1:0] modv,
                                                       input logic [DATA_W-1:0] expv);
      longint unsigned m;
      longint unsigned square;
      longint unsigned acc;
      m = modv;
      if (m == 0) begin
         return '0;
      end
      square = base % m;
      acc    = 64'd1 % m;
      for (int i = 0; i < DATA_W; i++) begin
         if (expv[i]) begin
            acc = (acc * square) % m;
         end
         square = (square * square) % m;
      end
      return acc[DATA_W-1:0];
   endfunction

   // Mix of boundary bases and random ones, some already below the modulus.
   function automatic logic [DATA_W-1:0] pick_base(input logic [DATA_W-1:0] m);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return m - 1;
         3: return m;
         4: return 32'd1;
         5, 6: return (m == 0) ? $urandom : $urandom % m;
         default: return $urandom;
      endcase
   endfunction

   // Write a register, then read it back in the next transfer.
   task automatic write_register(input logic reg_index, input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (reg_index == REG_MODULUS) begin
         cur_modulus = value;
      end else begin
         cur_exponent = value;
      end
      // Turn straight into the setup cycle of the read.
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== value) begin
         report_error($sformatf("register %0d read %h, wrote %h", reg_index, csr_prdata, value));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_key(input logic [DATA_W-1:0] modv, input logic [DATA_W-1:0] expv);
      write_register(REG_MODULUS, modv);
      write_register(REG_EXPONENT, expv);
   endtask

   // Offer one base word, record its expected power once accepted, maybe idle afterwards.
   task automatic send_base(input logic [DATA_W-1:0] base);
      power_entry_type entry;
      req_bus.valid      <= 1'b1;
      req_bus.base_value <= base;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      entry.base_value   = base;
      entry.modulus      = cur_modulus;
      entry.exponent     = cur_exponent;
      entry.power_result = predict_power(base, cur_modulus, cur_exponent);
      pending_powers.push_back(entry);
      if (!quiet_run && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every expected word has come back.
   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (pending_powers.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stall bursts, long hold-offs on request, none in the quiet stretch.
   initial begin : result_receiver
      int stall_left;
      int hold_left;
      stall_left   = 0;
      hold_left    = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      power_entry_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_powers.size() == 0) begin
            report_error($sformatf("unexpected result word %h", rsp_bus.power_result));
         end else begin
            want = pending_powers.pop_front();
            if (rsp_bus.power_result !== want.power_result) begin
               report_error($sformatf("base %h mod %h exp %h: power_result %h, want %h",
                                      want.base_value, want.modulus, want.exponent,
                                      rsp_bus.power_result, want.power_result));
            end
         end
      end
   end

   // Reset values: modulus 1 and exponent 1 give zero for any base.
   task automatic test_reset_defaults();
      send_base('0);
      send_base('1);
      send_base(32'd12345);
      wait_drain();
   endtask

   // Extreme operands and each special case.
   task automatic test_directed_edges();
      // Largest modulus and exponent.
      set_key('1, '1);
      send_base('0);
      send_base(32'd1);
      send_base('1);
      send_base(32'hFFFF_FFFE);
      send_base(32'h8000_0000);
      wait_drain();
      // Zero exponent gives one.
      set_key(32'hFFFF_FFFB, '0);
      send_base('0);
      send_base('1);
      wait_drain();
      // Modulus of one gives zero.
      set_key(32'd1, $urandom);
      send_base('1);
      wait_drain();
      // Zero modulus answers zero.
      set_key('0, 32'd5);
      send_base(32'd7);
      send_base('1);
      wait_drain();
      set_key(32'd2, 32'd3);
      send_base(32'd3);
      send_base(32'd4);
      wait_drain();
      // Bases far above the modulus are reduced first.
      set_key(32'd1000, 32'd65537);
      send_base('1);
      send_base(32'd999);
      send_base(32'd1000);
      wait_drain();
      set_key(32'h8000_0000, 32'h8000_0001);
      send_base(32'h7FFF_FFFF);
      send_base(32'd3);
      wait_drain();
   endtask

   // Several random keys, each with a batch of random base words.
   task automatic test_random_keys();
      logic [DATA_W-1:0] modv;
      logic [DATA_W-1:0] expv;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 5))
            0: modv = $urandom | 32'h8000_0000;
            1: modv = $urandom_range(2, 255);
            2: modv = $urandom_range(256, 65535);
            3: modv = $urandom;
            4: modv = 32'hFFFF_FFFF - $urandom_range(0, 16);
            default: modv = $urandom_range(1, 3);
         endcase
         case ($urandom_range(0, 5))
            0: expv = $urandom_range(1, 20);
            1: expv = 32'd65537;
            2: expv = (phase == 3) ? '0 : $urandom;
            3: expv = '1;
            default: expv = $urandom;
         endcase
         set_key(modv, expv);
         repeat (26) send_base(pick_base(modv));
         wait_drain();
      end
   endtask

   // Hold the receiver off long enough that the block fills and stalls its input.
   task automatic test_backpressure();
      set_key($urandom | 32'h8000_0000, $urandom);
      hold_request = LONG_HOLD;
      repeat (6) send_base(pick_base(cur_modulus));
      // Pause the sender until everything has come back.
      wait_drain();
   endtask

   // Final stretch with no idling on either side.
   task automatic test_quiet_stream();
      set_key($urandom, $urandom);
      quiet_run = 1'b1;
      repeat (36) send_base(pick_base(cur_modulus));
      wait_drain();
   endtask

   initial begin
      error_count  = 0;
      quiet_run    = 1'b0;
      hold_request = 0;
      cur_modulus  = 32'd1;
      cur_exponent = 32'd1;
      reset              <= 1'b1;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.base_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_edges();
      test_random_keys();
      test_backpressure();
      test_quiet_stream();

      // Let any stray word show up before the verdict.
      repeat (BLOCK_LATENCY) @(posedge clock);
      if (error_count == 0 && pending_powers.size() == 0) begin
         $display("modular_exponentiation regression: pass");
      end else begin
         $display("modular_exponentiation regression: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/modexp_pkg.sv
design/modexp_if.sv
design/modexp_mulmod.sv
design/modexp_dp.sv
design/modexp_ctrl.sv
design/modular_exponentiation.sv
design/modexp_checker.sv
verif/tb_modular_exponentiation.sv
